// File: rtl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// Masked Hamming score package
// Shared widths, operation codes and word types for the masked Hamming score
// block.
// ----------------------------------------------------------------------------
package mhs_pkg;

   localparam int unsigned WORD_W            = 64;
   localparam int unsigned IDX_W             = 4;
   localparam int unsigned STORE_DEPTH       = 16;
   localparam int unsigned POP_W             = 7;
   localparam int unsigned CNT_W             = 11;
   localparam int unsigned SCORE_W           = 13;
   localparam int unsigned WORDS_PER_ROW_DEF = 16;

   localparam logic [1:0] OP_LOAD_SIGN = 2'd0;
   localparam logic [1:0] OP_LOAD_MASK = 2'd1;
   localparam logic [1:0] OP_ROW       = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [IDX_W-1:0]  word_index;
      logic [WORD_W-1:0] word_value;
   } req_word_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [CNT_W-1:0]          mismatch_count;
   } rsp_word_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       operation;
      logic             row_end;
      logic [POP_W-1:0] count_new;
      logic [POP_W-1:0] count_old;
   } pop_word_type;

endpackage

// File: rtl/mhs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module mhs_ram #(
   parameter int unsigned DataWidth = 64,
   parameter int unsigned Depth     = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [DataWidth-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [DataWidth-1:0]     rd_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mhs_lookup.sv
// ----------------------------------------------------------------------------
// Query store and bit count stage
// Holds the sign and mask stores, forwards a write to a read of the same
// entry by the next request, and counts the bits each word contributes.
// ----------------------------------------------------------------------------
module mhs_lookup #(
   parameter int unsigned WORDS_PER_ROW = mhs_pkg::WORDS_PER_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  req_valid,
   input  mhs_pkg::req_word_type req_word,
   output mhs_pkg::pop_word_type pop_word
);
   import mhs_pkg::*;

   localparam logic [IDX_W-1:0] LastIndex = IDX_W'((WORDS_PER_ROW - 1) % STORE_DEPTH);

   function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
      logic [POP_W-1:0] part [WORD_W];
      for (int i = 0; i < WORD_W; i++) begin
         part[i] = POP_W'(v[i]);
      end
      for (int span = 1; span < WORD_W; span = span * 2) begin
         for (int i = 0; i < WORD_W; i = i + 2 * span) begin
            part[i] = part[i] + part[i + span];
         end
      end
      return part[0];
   endfunction

   logic                   s1_valid_ff;
   logic [1:0]             s1_op_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic [WORD_W-1:0]      s1_value_ff;
   logic [STORE_DEPTH-1:0] sign_vld_ff, sign_vld_in;
   logic [STORE_DEPTH-1:0] mask_vld_ff, mask_vld_in;
   logic                   sign_hit_ff, mask_hit_ff;
   logic                   sign_fwd_ff, mask_fwd_ff;
   logic [WORD_W-1:0]      fwd_data_ff;
   logic                   sign_we, mask_we;
   logic [WORD_W-1:0]      sign_rd, mask_rd;
   logic [WORD_W-1:0]      sign_eff, mask_eff;
   pop_word_type           pop_word_ff, pop_word_in;

   assign sign_we = advance && s1_valid_ff && (s1_op_ff == OP_LOAD_SIGN);
   assign mask_we = advance && s1_valid_ff && (s1_op_ff == OP_LOAD_MASK);

   mhs_ram #(.DataWidth(WORD_W), .Depth(STORE_DEPTH)) u_sign_ram (
      .clock   (clock),
      .wr_en   (sign_we),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_value_ff),
      .rd_en   (advance),
      .rd_addr (req_word.word_index),
      .rd_data (sign_rd)
   );

   mhs_ram #(.DataWidth(WORD_W), .Depth(STORE_DEPTH)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_value_ff),
      .rd_en   (advance),
      .rd_addr (req_word.word_index),
      .rd_data (mask_rd)
   );

   always_comb begin
      sign_vld_in = sign_vld_ff;
      mask_vld_in = mask_vld_ff;
      if (sign_we) begin
         sign_vld_in[s1_idx_ff] = 1'b1;
      end
      if (mask_we) begin
         mask_vld_in[s1_idx_ff] = 1'b1;
      end
   end

   // Entries never written read as zero; a forwarded write from the preceding request wins.
   assign sign_eff = sign_fwd_ff ? fwd_data_ff : (sign_hit_ff ? sign_rd : '0);
   assign mask_eff = mask_fwd_ff ? fwd_data_ff : (mask_hit_ff ? mask_rd : '0);

   always_comb begin
      pop_word_in.valid     = s1_valid_ff;
      pop_word_in.operation = s1_op_ff;
      pop_word_in.row_end   = (s1_idx_ff == LastIndex);
      pop_word_in.count_old = popcount64(mask_eff);
      if (s1_op_ff == OP_LOAD_MASK) begin
         pop_word_in.count_new = popcount64(s1_value_ff);
      end else begin
         pop_word_in.count_new = popcount64((s1_value_ff ^ sign_eff) & mask_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sign_vld_ff <= '0;
         mask_vld_ff <= '0;
         sign_hit_ff <= 1'b0;
         mask_hit_ff <= 1'b0;
         sign_fwd_ff <= 1'b0;
         mask_fwd_ff <= 1'b0;
         pop_word_ff <= '0;
      end else begin
         sign_vld_ff <= sign_vld_in;
         mask_vld_ff <= mask_vld_in;
         if (advance) begin
            s1_valid_ff <= req_valid;
            sign_hit_ff <= sign_vld_ff[req_word.word_index];
            mask_hit_ff <= mask_vld_ff[req_word.word_index];
            sign_fwd_ff <= sign_we && (s1_idx_ff == req_word.word_index);
            mask_fwd_ff <= mask_we && (s1_idx_ff == req_word.word_index);
            pop_word_ff <= pop_word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= req_word.operation;
         s1_idx_ff   <= req_word.word_index;
         s1_value_ff <= req_word.word_value;
         fwd_data_ff <= s1_value_ff;
      end
   end

   assign pop_word = pop_word_ff;

endmodule

// File: rtl/mhs_accum.sv
// ----------------------------------------------------------------------------
// Accumulate and score stage
// Keeps the mask bit total and the row accumulator, forms the score at the
// end of a row and holds it in the output register.
// ----------------------------------------------------------------------------
module mhs_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  mhs_pkg::pop_word_type pop_word,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mhs_pkg::rsp_word_type rsp_word
);
   import mhs_pkg::*;

   localparam int ScoreFloor = -(2 ** (SCORE_W - 1));
   localparam int ScoreCeil  = (2 ** (SCORE_W - 1)) - 1;
   localparam logic [CNT_W-1:0] AccMax = {CNT_W{1'b1}};

   logic [CNT_W-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]          acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;
   logic                      emits, retire;
   logic [CNT_W:0]            acc_sum;
   logic [CNT_W-1:0]          acc_sat;
   logic signed [SCORE_W+1:0] score_wide;
   logic signed [SCORE_W-1:0] score_sat;

   assign emits   = pop_word.valid && (pop_word.operation == OP_ROW) && pop_word.row_end;
   assign advance = !(emits && rsp_valid_ff && !rsp_ready);
   assign retire  = advance && pop_word.valid;

   assign acc_sum    = {1'b0, acc_ff} + (CNT_W + 1)'(pop_word.count_new);
   assign acc_sat    = acc_sum[CNT_W] ? AccMax : acc_sum[CNT_W-1:0];
   assign score_wide = $signed({3'b000, total_ff, 1'b0}) - $signed({2'b00, acc_sat, 2'b00});

   always_comb begin
      if (score_wide < (SCORE_W + 2)'(ScoreFloor)) begin
         score_sat = SCORE_W'(ScoreFloor);
      end else if (score_wide > (SCORE_W + 2)'(ScoreCeil)) begin
         score_sat = SCORE_W'(ScoreCeil);
      end else begin
         score_sat = score_wide[SCORE_W-1:0];
      end
   end

   always_comb begin
      total_in     = total_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (retire) begin
         unique case (pop_word.operation)
            OP_LOAD_MASK: begin
               total_in = total_ff - CNT_W'(pop_word.count_old) + CNT_W'(pop_word.count_new);
            end
            OP_ROW: begin
               if (pop_word.row_end) begin
                  rsp_valid_in               = 1'b1;
                  rsp_word_in.score          = score_sat;
                  rsp_word_in.mismatch_count = acc_sat;
                  acc_in                     = '0;
               end else begin
                  acc_in = acc_sat;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/masked_hamming_score.sv
// Takes one word per cycle on the request channel and never stalls it except
// when a row's last word has its score ready while the previous score still
// sits unread in the response register. The score is registered there after
// the row's last word passes the lookup stage and pop word registers. Sign
// and mask words live in two 16-entry RAMs with registered reads; a written
// word is forwarded to a read of the same entry by the next request; per-entry
// valid bits make unwritten entries read as zero, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Masked Hamming score top level
// Scores streamed row words against a stored sign and mask query.
// ----------------------------------------------------------------------------
module masked_hamming_score #(
   parameter int unsigned WORDS_PER_ROW = mhs_pkg::WORDS_PER_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mhs_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mhs_pkg::rsp_word_type rsp_word
);
   import mhs_pkg::*;

   logic         advance;
   pop_word_type pop_word;

   mhs_lookup #(.WORDS_PER_ROW(WORDS_PER_ROW)) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_word  (req_word),
      .pop_word  (pop_word)
   );

   mhs_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .pop_word  (pop_word),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign req_ready = advance;

   stall_only_on_held_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a held response");

   clean_row_scores_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.mismatch_count == '0)) |-> (rsp_word.score >= 0))
      else $error("row with no mismatches has a negative score");

   score_within_mask_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.score <= 13'sd2048))
      else $error("score exceeds twice the largest mask bit total");

endmodule
